[src/lrpw_pkg.sv]
// ----------------------------------------------------------------------------
// lrpw_pkg
// Types and constants shared by the line rasterizer pixel writer.
// ----------------------------------------------------------------------------
package lrpw_pkg;

    localparam int COORD_W   = 11;   // signed pixel coordinate
    localparam int DELTA_W   = 12;   // absolute endpoint difference
    localparam int ERR_W     = 14;   // signed Bresenham error term
    localparam int COLOR_W   = 8;
    localparam int OFFSET_W  = 15;   // halfword offset within a page
    localparam int LIN_W     = 21;   // full linear pixel index y*width+x

    localparam int S_TDATA_W = 56;   // 52 payload bits padded to bytes
    localparam int M_TDATA_W = 48;   // 47 payload bits padded to bytes

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register index taken from paddr[2].
    localparam logic REG_PAGE_SELECT = 1'b0;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [DELTA_W-1:0] delta_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic        [COLOR_W-1:0] color_t;

endpackage

[src/line_rasterizer_pixel_writer_unit.sv]
// ----------------------------------------------------------------------------
// line_rasterizer_pixel_writer_unit
// Bresenham line stepper producing frame buffer pixel writes.
// ----------------------------------------------------------------------------
// A start transfer (tuser = 0) loads both endpoints and the color and yields
// the first pixel; each step transfer (tuser = 1) yields the next pixel, and a
// step after the end point yields nothing. The unit takes one transfer per
// cycle and delivers one pixel per cycle unless m_tready stalls the output:
// the step logic sits between the input and a pipeline register, and the
// on-screen test and the y*width+x offset sit between that register and the
// output register, which drives the master side. Off-screen pixels are
// delivered with on_screen low and a zero offset.
module line_rasterizer_pixel_writer_unit
    import lrpw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 160
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33], color[51:44]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic [0:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x[10:0], pixel_y[21:11], word_offset[36:22], page[37],
    // high_byte[38], pixel_color[46:39]
    output logic [M_TDATA_W-1:0] m_tdata,
    // on_screen[0]
    output logic [0:0]           m_tuser,
    output logic                 m_tlast,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ---------------- configuration ----------------
    logic page_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PAGE_SELECT) begin
            page_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_PAGE_SELECT) ? {{(PDATA_W-1){1'b0}}, page_reg}
                                                  : '0;

    // ---------------- line state ----------------
    coord_t cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    delta_t dx_reg, dy_reg;
    logic   neg_x_reg, neg_y_reg;
    err_t   err_reg;
    color_t color_reg;
    logic   active_reg;

    coord_t cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
    delta_t dx_next, dy_next;
    logic   neg_x_next, neg_y_next;
    err_t   err_next;
    color_t color_next;
    logic   active_next;
    logic   produce;
    logic   is_last;

    // Pipeline register between step logic and address logic.
    logic   p1_valid_reg;
    coord_t p1_x_reg, p1_y_reg;
    color_t p1_color_reg;
    logic   p1_last_reg;
    logic   p1_page_reg;

    // Output register.
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                out_on_reg;
    logic                out_last_reg;

    logic out_en, p1_en, accept;

    assign out_en   = !out_valid_reg || m_tready;
    assign p1_en    = !p1_valid_reg || out_en;
    assign s_tready = p1_en;
    assign accept   = s_tvalid && p1_en;

    // Input field unpacking.
    coord_t in_sx, in_sy, in_ex, in_ey;
    color_t in_color;
    cmd_t   in_cmd;

    assign in_sx    = s_tdata[10:0];
    assign in_sy    = s_tdata[21:11];
    assign in_ex    = s_tdata[32:22];
    assign in_ey    = s_tdata[43:33];
    assign in_color = s_tdata[51:44];
    assign in_cmd   = cmd_t'(s_tuser);

    logic signed [DELTA_W-1:0]   diff_x, diff_y;
    logic signed [ERR_W:0]       e2;
    logic signed [ERR_W:0]       neg_dy;
    logic                        move_x, move_y;

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        produce     = 1'b0;

        diff_x = {in_ex[COORD_W-1], in_ex} - {in_sx[COORD_W-1], in_sx};
        diff_y = {in_ey[COORD_W-1], in_ey} - {in_sy[COORD_W-1], in_sy};
        e2     = {err_reg, 1'b0};
        neg_dy = -$signed({{(ERR_W+1-DELTA_W){1'b0}}, dy_reg});
        move_x = e2 > neg_dy;
        move_y = e2 < $signed({{(ERR_W+1-DELTA_W){1'b0}}, dx_reg});

        if (in_cmd == CMD_START) begin
            produce    = 1'b1;
            cur_x_next = in_sx;
            cur_y_next = in_sy;
            tgt_x_next = in_ex;
            tgt_y_next = in_ey;
            color_next = in_color;
            dx_next    = diff_x[DELTA_W-1] ? delta_t'(-diff_x) : delta_t'(diff_x);
            dy_next    = diff_y[DELTA_W-1] ? delta_t'(-diff_y) : delta_t'(diff_y);
            neg_x_next = diff_x[DELTA_W-1] || (diff_x == '0);
            neg_y_next = diff_y[DELTA_W-1] || (diff_y == '0);
            err_next   = $signed({{(ERR_W-DELTA_W){1'b0}}, dx_next})
                       - $signed({{(ERR_W-DELTA_W){1'b0}}, dy_next});
        end else if (active_reg) begin
            produce  = 1'b1;
            err_next = err_reg
                     - (move_x ? $signed({{(ERR_W-DELTA_W){1'b0}}, dy_reg}) : err_t'(0))
                     + (move_y ? $signed({{(ERR_W-DELTA_W){1'b0}}, dx_reg}) : err_t'(0));
            if (move_x) begin
                cur_x_next = cur_x_reg + (neg_x_reg ? coord_t'(-1) : coord_t'(1));
            end
            if (move_y) begin
                cur_y_next = cur_y_reg + (neg_y_reg ? coord_t'(-1) : coord_t'(1));
            end
        end

        is_last     = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        active_next = produce ? !is_last : active_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            neg_x_reg  <= 1'b0;
            neg_y_reg  <= 1'b0;
            err_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

    // ---------------- pipeline stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_en) begin
            p1_valid_reg <= accept && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_en) begin
            p1_x_reg     <= cur_x_next;
            p1_y_reg     <= cur_y_next;
            p1_color_reg <= color_next;
            p1_last_reg  <= is_last;
            p1_page_reg  <= page_reg;
        end
    end

    // ---------------- address stage ----------------
    logic              on_screen;
    logic [LIN_W-1:0]  lin_index;
    logic [OFFSET_W-1:0] word_offset;

    assign on_screen = !p1_x_reg[COORD_W-1] && !p1_y_reg[COORD_W-1]
                    && ({1'b0, p1_x_reg[COORD_W-2:0]} < COORD_W'(SCREEN_WIDTH))
                    && ({1'b0, p1_y_reg[COORD_W-2:0]} < COORD_W'(SCREEN_HEIGHT));

    // Constant-coefficient multiply; the screen limits keep both coordinates
    // in their low ten bits whenever the pixel is on screen.
    assign lin_index = LIN_W'(p1_y_reg[COORD_W-2:0]) * LIN_W'(SCREEN_WIDTH)
                     + LIN_W'(p1_x_reg[COORD_W-2:0]);
    assign word_offset = on_screen ? lin_index[OFFSET_W:1] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_data_reg <= {1'b0, p1_color_reg, p1_x_reg[0], p1_page_reg,
                             word_offset, p1_y_reg, p1_x_reg};
            out_on_reg   <= on_screen;
            out_last_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_on_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_idle_step_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_STEP && !active_reg) |=> !p1_valid_reg)
        else $error("step without an active line produced a pixel");

    a_start_produces: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_START) |=> p1_valid_reg)
        else $error("start transfer produced no pixel");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && produce) |=> (active_reg == !p1_last_reg))
        else $error("line activity disagrees with the end-point flag");

    a_offscreen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_on_reg) |-> (out_data_reg[36:22] == '0))
        else $error("off-screen pixel carries a nonzero offset");

endmodule
